// ===== design/rlgr1_pkg.sv =====
// Shared types and constants for the RLGR1 entropy decoder.
package rlgr1_pkg;

  // Default parameter values
  localparam int unsigned MaxCoeffsDef  = 4096;
  localparam int unsigned ParamLimitDef = 80;

  // Fixed field widths
  localparam int unsigned CntW   = 13;
  localparam int unsigned ValW   = 16;
  localparam int unsigned ParamW = 7;

  // Reset value of the coefficient count register
  localparam logic [CntW-1:0] CoeffCountRst = 13'd4096;

  // Adaptive parameter start value and step sizes
  localparam logic [ParamW-1:0] ParamInit = 7'd8;
  localparam logic [7:0]        RunUp     = 8'd4;
  localparam logic [7:0]        RunDown   = 8'd6;
  localparam logic [7:0]        GrStep    = 8'd3;
  localparam logic [7:0]        CodeDown  = 8'd2;

  // Symbol decoding phase
  typedef enum logic [2:0] {
    PH_START   = 3'd0,
    PH_RL_RUN  = 3'd1,
    PH_RL_REM  = 3'd2,
    PH_RL_SIGN = 3'd3,
    PH_RL_MAG  = 3'd4,
    PH_RL_MREM = 3'd5,
    PH_GR_MAG  = 3'd6,
    PH_GR_MREM = 3'd7
  } phase_e;

  // Byte sequencer state
  typedef enum logic [1:0] {
    SEQ_IDLE  = 2'd0,
    SEQ_BITS  = 2'd1,
    SEQ_FINAL = 2'd2
  } seq_e;

  // Commands from the sequencer to the bit decoder
  typedef struct packed {
    logic step;
    logic bit_val;
    logic finish;
  } ctrl_t;

  // One decoded result
  typedef struct packed {
    logic [CntW-1:0] zeros_before;
    logic [ValW-1:0] value;
    logic            has_value;
    logic            end_of_tile;
  } result_t;

endpackage

// ===== design/rlgr1_bit_decoder.sv =====
// Bit-serial RLGR1 symbol decoder: consumes one stream bit per step.
module rlgr1_bit_decoder #(
  parameter int unsigned MAX_COEFFS  = rlgr1_pkg::MaxCoeffsDef,
  parameter int unsigned PARAM_LIMIT = rlgr1_pkg::ParamLimitDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  rlgr1_pkg::ctrl_t            ctrl_i,
  input  logic [rlgr1_pkg::CntW-1:0]  coeff_count_i,
  output logic                        res_valid_o,
  output rlgr1_pkg::result_t          res_o
);

  localparam int unsigned PendW = $clog2(MAX_COEFFS + 1);
  localparam int unsigned SumW  = ((PendW > 16) ? PendW : 16) + 1;
  localparam int unsigned ZW    = (PendW > rlgr1_pkg::CntW) ? PendW : rlgr1_pkg::CntW;
  localparam logic [7:0]      Limit8 = 8'(PARAM_LIMIT);
  localparam logic [SumW-1:0] MaxSum = SumW'(MAX_COEFFS);

  localparam int unsigned CW = rlgr1_pkg::CntW;
  localparam int unsigned PW = rlgr1_pkg::ParamW;

  rlgr1_pkg::phase_e phase_q, phase_d;
  logic [PW-1:0]    kp_q, kp_d, krp_q, krp_d;
  logic [31:0]      unary_q, unary_d;
  logic [3:0]       rleft_q, rleft_d;
  logic [15:0]      racc_q, racc_d;
  logic [PendW-1:0] pend_q, pend_d;
  logic             sign_q, sign_d;
  logic [CW-1:0]    emit_q, emit_d;

  logic [CW-1:0]     cnt;
  logic [3:0]        k, kr;
  rlgr1_pkg::phase_e ph;
  logic [31:0]       un;
  logic [PendW-1:0]  pe;
  logic [SumW-1:0]   sum;
  logic [15:0]       acc_n, fin_rem, ushift, code, mag, half, gr_val;
  logic [16:0]       c1;
  logic [3:0]        left_n;
  logic              do_fin, fin_rl, b;
  logic [7:0]        kp_ext;
  logic [CW-1:0]     left, z, emit_n;

  // Clamp the count to the configured maximum
  always_comb begin
    if ({19'd0, coeff_count_i} > 32'(MAX_COEFFS)) begin
      cnt = CW'(MAX_COEFFS);
    end else begin
      cnt = coeff_count_i;
    end
  end

  assign k  = kp_q[PW-1:3];
  assign kr = krp_q[PW-1:3];
  assign b  = ctrl_i.bit_val;

  // Next state and result for one bit
  always_comb begin
    phase_d = phase_q;
    kp_d    = kp_q;
    krp_d   = krp_q;
    unary_d = unary_q;
    rleft_d = rleft_q;
    racc_d  = racc_q;
    pend_d  = pend_q;
    sign_d  = sign_q;
    emit_d  = emit_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    ph      = phase_q;
    un      = unary_q;
    pe      = pend_q;
    sum     = '0;
    acc_n   = {racc_q[14:0], b};
    left_n  = rleft_q - 4'd1;
    do_fin  = 1'b0;
    fin_rem = '0;
    fin_rl  = 1'b0;
    ushift  = '0;
    code    = '0;
    mag     = '0;
    c1      = '0;
    half    = '0;
    gr_val  = '0;
    kp_ext  = {1'b0, kp_q};
    left    = '0;
    z       = '0;
    emit_n  = '0;

    if (ctrl_i.finish) begin
      // Emit the zero fill that closes the stream, then restart
      res_valid_o        = 1'b1;
      res_o.zeros_before = cnt - emit_q;
      res_o.end_of_tile  = 1'b1;
      phase_d = rlgr1_pkg::PH_START;
      kp_d    = rlgr1_pkg::ParamInit;
      krp_d   = rlgr1_pkg::ParamInit;
      unary_d = '0;
      rleft_d = '0;
      racc_d  = '0;
      pend_d  = '0;
      sign_d  = 1'b0;
      emit_d  = '0;
    end else if (ctrl_i.step &&
                 !(phase_q == rlgr1_pkg::PH_START && emit_q >= cnt)) begin
      // Open a new symbol in the mode that k selects
      if (phase_q == rlgr1_pkg::PH_START) begin
        un = '0;
        pe = '0;
        ph = (k != 4'd0) ? rlgr1_pkg::PH_RL_RUN : rlgr1_pkg::PH_GR_MAG;
      end
      unary_d = un;
      pend_d  = pe;
      phase_d = ph;

      unique case (ph)
        rlgr1_pkg::PH_RL_RUN: begin
          if (!b) begin
            sum    = SumW'(pe) + (SumW'(1) << k);
            pend_d = (sum > MaxSum) ? PendW'(MAX_COEFFS) : sum[PendW-1:0];
            kp_ext = {1'b0, kp_q} + rlgr1_pkg::RunUp;
            kp_d   = (kp_ext > Limit8) ? PW'(PARAM_LIMIT) : kp_ext[PW-1:0];
          end else begin
            rleft_d = k;
            racc_d  = '0;
            phase_d = (k != 4'd0) ? rlgr1_pkg::PH_RL_REM : rlgr1_pkg::PH_RL_SIGN;
          end
        end
        rlgr1_pkg::PH_RL_REM: begin
          racc_d  = acc_n;
          rleft_d = left_n;
          if (left_n == 4'd0) begin
            sum     = SumW'(pe) + SumW'(acc_n);
            pend_d  = (sum > MaxSum) ? PendW'(MAX_COEFFS) : sum[PendW-1:0];
            phase_d = rlgr1_pkg::PH_RL_SIGN;
          end
        end
        rlgr1_pkg::PH_RL_SIGN: begin
          sign_d  = b;
          unary_d = '0;
          phase_d = rlgr1_pkg::PH_RL_MAG;
        end
        rlgr1_pkg::PH_RL_MAG, rlgr1_pkg::PH_GR_MAG: begin
          if (b) begin
            unary_d = un + 32'd1;
          end else begin
            rleft_d = kr;
            racc_d  = '0;
            if (kr == 4'd0) begin
              do_fin  = 1'b1;
              fin_rem = '0;
            end else begin
              phase_d = (ph == rlgr1_pkg::PH_RL_MAG) ? rlgr1_pkg::PH_RL_MREM
                                                     : rlgr1_pkg::PH_GR_MREM;
            end
          end
        end
        rlgr1_pkg::PH_RL_MREM, rlgr1_pkg::PH_GR_MREM: begin
          racc_d  = acc_n;
          rleft_d = left_n;
          if (left_n == 4'd0) begin
            do_fin  = 1'b1;
            fin_rem = acc_n;
          end
        end
        default: begin
          // symbol start is resolved above
        end
      endcase

      // Close the magnitude code and adapt the parameters
      if (do_fin) begin
        fin_rl  = (ph == rlgr1_pkg::PH_RL_MAG) || (ph == rlgr1_pkg::PH_RL_MREM);
        ushift  = un[15:0] << kr;
        code    = fin_rem | ushift;
        phase_d = rlgr1_pkg::PH_START;
        if (un == 32'd0) begin
          krp_d = ({1'b0, krp_q} > rlgr1_pkg::CodeDown) ? krp_q - PW'(rlgr1_pkg::CodeDown)
                                                      : '0;
        end else if (un != 32'd1) begin
          if (un >= 32'(PARAM_LIMIT) || (32'(krp_q) + un) > 32'(PARAM_LIMIT)) begin
            krp_d = PW'(PARAM_LIMIT);
          end else begin
            krp_d = krp_q + un[PW-1:0];
          end
        end
        res_valid_o = 1'b1;
        if (fin_rl) begin
          mag    = sign_q ? (16'd0 - (code + 16'd1)) : (code + 16'd1);
          left   = cnt - emit_q;
          z      = (ZW'(pe) < ZW'(left)) ? pe[CW-1:0] : left;
          emit_n = emit_q + z;
          kp_d   = ({1'b0, kp_q} > rlgr1_pkg::RunDown) ? kp_q - PW'(rlgr1_pkg::RunDown)
                                                      : '0;
          res_o.zeros_before = z;
          if (emit_n < cnt) begin
            emit_d          = emit_n + CW'(1);
            res_o.value     = mag;
            res_o.has_value = 1'b1;
          end else begin
            emit_d = emit_n;
          end
        end else begin
          c1   = {1'b0, code} + 17'd1;
          half = c1[16:1];
          if (code == 16'd0) begin
            kp_ext = {1'b0, kp_q} + rlgr1_pkg::GrStep;
            kp_d   = (kp_ext > Limit8) ? PW'(PARAM_LIMIT) : kp_ext[PW-1:0];
            gr_val = '0;
          end else begin
            kp_d   = ({1'b0, kp_q} > rlgr1_pkg::GrStep) ? kp_q - PW'(rlgr1_pkg::GrStep)
                                                       : '0;
            gr_val = code[0] ? (16'd0 - half) : {1'b0, code[15:1]};
          end
          emit_d          = emit_q + CW'(1);
          res_o.value     = gr_val;
          res_o.has_value = 1'b1;
        end
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= rlgr1_pkg::PH_START;
      kp_q    <= rlgr1_pkg::ParamInit;
      krp_q   <= rlgr1_pkg::ParamInit;
      unary_q <= '0;
      rleft_q <= '0;
      racc_q  <= '0;
      pend_q  <= '0;
      sign_q  <= 1'b0;
      emit_q  <= '0;
    end else begin
      phase_q <= phase_d;
      kp_q    <= kp_d;
      krp_q   <= krp_d;
      unary_q <= unary_d;
      rleft_q <= rleft_d;
      racc_q  <= racc_d;
      pend_q  <= pend_d;
      sign_q  <= sign_d;
      emit_q  <= emit_d;
    end
  end

endmodule

// ===== design/rlgr1_out_reg.sv =====
// Output register that holds one result until the receiver takes it.
module rlgr1_out_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  rlgr1_pkg::result_t data_i,
  input  logic               ready_i,
  output logic               valid_o,
  output rlgr1_pkg::result_t data_o,
  output logic               free_o
);

  logic               valid_q, valid_d;
  rlgr1_pkg::result_t data_q;

  // The slot is free when empty or being drained this cycle
  assign free_o  = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_comb begin
    valid_d = valid_q;
    if (push_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Load payload on push
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      data_q <= data_i;
    end
  end

endmodule

// ===== design/rlgr1_entropy_decoder_top.sv =====
// Top level of the RLGR1 entropy decoder: byte sequencer, config and outputs.
//
// The slave stream carries the encoded bitstream one byte per request,
// most significant bit first, with tlast on the final byte of a stream.
// Each byte is shifted through the bit decoder one bit per cycle while the
// output slot is free: the sequencer accepts the byte, then steps its eight
// bits; a last byte is then followed by the closing zero-fill result.
// s_axis_tready is high only while the sequencer waits for a byte.
// The master stream carries up to one result per bit step, plus the
// closing result with tlast set. tuser is the has_value flag.
// A single output register sits between decoder and receiver; when the
// receiver stalls with a result held, the bit steps pause until the slot
// drains, so nothing is lost. tvalid rises in the cycle after the deciding bit.
// The config channel writes the coefficient count at any time; it must
// only be changed while no stream is in progress. cfg_ready is always high.
// Reset clears all decoder state, empties the output register and sets
// the coefficient count to 4096; each stream starts again after tlast.
module rlgr1_entropy_decoder_top #(
  parameter int unsigned MAX_COEFFS  = rlgr1_pkg::MaxCoeffsDef,
  parameter int unsigned PARAM_LIMIT = rlgr1_pkg::ParamLimitDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Config channel
  input  logic        cfg_valid_i,
  input  logic [12:0] cfg_data_i,
  output logic        cfg_ready_o,
  // Input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] stream_byte
  input  logic        s_axis_tlast,   // last_byte
  // Output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [12:0] zeros_before, [28:13] value, rest zero
  output logic        m_axis_tuser,   // [0] has_value
  output logic        m_axis_tlast    // end_of_tile
);

  rlgr1_pkg::seq_e   state_q, state_d;
  logic [7:0]        shift_q, shift_d;
  logic [2:0]        bitcnt_q, bitcnt_d;
  logic              last_q, last_d;
  logic [12:0]       coeff_q;

  rlgr1_pkg::ctrl_t   ctrl;
  logic               res_valid, free;
  rlgr1_pkg::result_t res, out_data;

  // Coefficient count register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coeff_q <= rlgr1_pkg::CoeffCountRst;
    end else if (cfg_valid_i) begin
      coeff_q <= cfg_data_i;
    end
  end

  // Byte sequencer: accept, step eight bits, then close the stream if last
  always_comb begin
    state_d       = state_q;
    shift_d       = shift_q;
    bitcnt_d      = bitcnt_q;
    last_d        = last_q;
    s_axis_tready = 1'b0;
    ctrl.step     = 1'b0;
    ctrl.bit_val  = shift_q[7];
    ctrl.finish   = 1'b0;
    unique case (state_q)
      rlgr1_pkg::SEQ_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          shift_d  = s_axis_tdata;
          last_d   = s_axis_tlast;
          bitcnt_d = '0;
          state_d  = rlgr1_pkg::SEQ_BITS;
        end
      end
      rlgr1_pkg::SEQ_BITS: begin
        if (free) begin
          ctrl.step = 1'b1;
          shift_d   = {shift_q[6:0], 1'b0};
          bitcnt_d  = bitcnt_q + 3'd1;
          if (bitcnt_q == 3'd7) begin
            state_d = last_q ? rlgr1_pkg::SEQ_FINAL : rlgr1_pkg::SEQ_IDLE;
          end
        end
      end
      rlgr1_pkg::SEQ_FINAL: begin
        if (free) begin
          ctrl.finish = 1'b1;
          state_d     = rlgr1_pkg::SEQ_IDLE;
        end
      end
      default: begin
        state_d = rlgr1_pkg::SEQ_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= rlgr1_pkg::SEQ_IDLE;
      bitcnt_q <= '0;
      last_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      bitcnt_q <= bitcnt_d;
      last_q   <= last_d;
    end
  end

  // Hold the byte being shifted out
  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
  end

  rlgr1_bit_decoder #(
    .MAX_COEFFS  (MAX_COEFFS),
    .PARAM_LIMIT (PARAM_LIMIT)
  ) u_dec (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .coeff_count_i (coeff_q),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  rlgr1_out_reg u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_valid),
    .data_i  (res),
    .ready_i (m_axis_tready),
    .valid_o (m_axis_tvalid),
    .data_o  (out_data),
    .free_o  (free)
  );

  // Pack the result onto the master stream
  assign m_axis_tdata = {3'b000, out_data.value, out_data.zeros_before};
  assign m_axis_tuser = out_data.has_value;
  assign m_axis_tlast = out_data.end_of_tile;

`ifndef SYNTHESIS
  // A result is only produced when the output slot can take it
  assert property (@(posedge clk_i) disable iff (!rst_ni) res_valid |-> free)
    else $error("decoder result produced while output slot is busy");

  // After a byte request is taken, no new byte is taken in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("byte accepted while previous byte still decoding");

  // The closing result never carries a coefficient
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (m_axis_tvalid && m_axis_tlast) |-> !m_axis_tuser)
    else $error("end of tile result marked as holding a value");

  // The closing result leaves the sequencer ready for the next stream
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   ctrl.finish |=> s_axis_tready)
    else $error("sequencer not idle after closing a stream");
`endif

endmodule
